/* rtl/core/sqe_pkg.sv */
// ============================================================================
// sqe_pkg
// Shared types and codes for the stack/queue engine.
// ============================================================================
package sqe_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUMP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SWAP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     has_value;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_result;

endpackage

/* rtl/core/stack_queue_engine.sv */
// ============================================================================
// stack_queue_engine
// Takes one item at a time. Push, pop, error and unknown items load their
// result into the output register on accept; peek reads the store first;
// swap reads both, then writes them in turn in S_SW1 and S_SW2 over the one
// write port; a dump gives one result per cycle while the sink takes them.
// Reset clears count, top, mode and control; the store stays undefined.
// ============================================================================
module stack_queue_engine #(
    parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,      // queue_mode
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [sqe_pkg::DATA_W-1:0]     i_s_axis_tdata,   // push_value
    input  logic [sqe_pkg::KIND_W-1:0]     i_s_axis_tuser,   // kind
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [sqe_pkg::DATA_W-1:0]     o_m_axis_tdata,   // out_value
    output logic [sqe_pkg::STATUS_W:0]     o_m_axis_tuser,   // status, has_value
    output logic                           o_m_axis_tlast    // last
);
    import sqe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SW1  = 2'd2;
    localparam logic [1:0] S_SW2  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_top, n_top;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [CW-1:0]     r_left, n_left;
    logic              r_qmode;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_wa, mem_aa, mem_ab;
    logic [DATA_W-1:0] mem_wd, rd_a, rd_b;

    logic              out_load, out_free;
    t_result           out_res, out_q;
    logic              accept;
    logic [AW-1:0]     below1, top_inc;

    function automatic logic [AW-1:0] f_below(input logic [AW-1:0] top,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] t;
        t = SW'(top) + SW'(DEPTH) - SW'(k);
        if (t >= SW'(DEPTH)) begin
            t = t - SW'(DEPTH);
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign below1  = f_below(r_top, CW'(1));
    assign top_inc = (r_top == AW'(DEPTH - 1)) ? '0 : r_top + 1'b1;

    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state  = r_state;
        n_top    = r_top;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_left   = r_left;
        mem_we   = 1'b0;
        mem_wa   = r_top;
        mem_wd   = i_s_axis_tdata;
        mem_re   = 1'b0;
        mem_aa   = r_top;
        mem_ab   = below1;
        out_load = 1'b0;
        out_res  = '{status: ST_OK, has_value: 1'b0, value: '0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_s_axis_tuser)
                        KIND_PUSH: begin
                            out_load = 1'b1;
                            if (r_cnt == CW'(DEPTH)) begin
                                out_res.status = ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_cnt  = r_cnt + 1'b1;
                                if (r_qmode) begin
                                    mem_wa = f_below(r_top, r_cnt);
                                end else begin
                                    mem_wa = top_inc;
                                    n_top  = top_inc;
                                end
                            end
                        end
                        KIND_DUMP: begin
                            if (r_cnt == '0) begin
                                out_load = 1'b1;
                            end else begin
                                mem_re  = 1'b1;
                                n_ptr   = f_dec(r_top);
                                n_left  = r_cnt - 1'b1;
                                n_state = S_READ;
                            end
                        end
                        KIND_PEEK: begin
                            if (r_cnt == '0) begin
                                out_load       = 1'b1;
                                out_res.status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_left  = '0;
                                n_state = S_READ;
                            end
                        end
                        KIND_POP: begin
                            out_load = 1'b1;
                            if (r_cnt == '0) begin
                                out_res.status = ST_EMPTY;
                            end else begin
                                n_top = below1;
                                n_cnt = r_cnt - 1'b1;
                            end
                        end
                        KIND_SWAP: begin
                            if (r_cnt < CW'(2)) begin
                                out_load       = 1'b1;
                                out_res.status = ST_SHORT;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_SW1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    out_load          = 1'b1;
                    out_res.has_value = 1'b1;
                    out_res.value     = rd_a;
                    out_res.last      = (r_left == '0);
                    if (r_left != '0) begin
                        mem_re = 1'b1;
                        mem_aa = r_ptr;
                        n_ptr  = f_dec(r_ptr);
                        n_left = r_left - 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SW1: begin
                mem_we  = 1'b1;
                mem_wa  = r_top;
                mem_wd  = rd_b;
                n_state = S_SW2;
            end
            S_SW2: begin
                if (out_free) begin
                    mem_we   = 1'b1;
                    mem_wa   = below1;
                    mem_wd   = rd_a;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_left  <= '0;
            r_qmode <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_qmode <= i_cfg_wdata;
            end
        end
    end

    sqe_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_wa),
        .i_wdata   (mem_wd),
        .i_re      (mem_re),
        .i_raddr_a (mem_aa),
        .i_raddr_b (mem_ab),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    sqe_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (out_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_q),
        .o_free  (out_free)
    );

    assign o_m_axis_tdata = out_q.value;
    assign o_m_axis_tuser = {out_q.has_value, out_q.status};
    assign o_m_axis_tlast = out_q.last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("element count above depth");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < AW'(DEPTH - 1) || r_top == AW'(DEPTH - 1))
        else $error("top index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over an untaken item");

    a_swap_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW1) |=> (r_state == S_SW2))
        else $error("swap sequence broken");

    a_read_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !mem_we)
        else $error("store written during read-out");

endmodule

/* rtl/core/sqe_mem.sv */
// ============================================================================
// sqe_mem
// Element store: one write port, two registered read ports.
// ============================================================================
module sqe_mem #(
    parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [sqe_pkg::DATA_W-1:0]       i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_b,
    output logic [sqe_pkg::DATA_W-1:0]       o_rdata_a,
    output logic [sqe_pkg::DATA_W-1:0]       o_rdata_b
);
    import sqe_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

/* rtl/core/sqe_out_reg.sv */
// ============================================================================
// sqe_out_reg
// Output register: holds one result item until the sink takes it.
// ============================================================================
module sqe_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sqe_pkg::t_result  i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output sqe_pkg::t_result  o_res,
    output logic              o_free
);
    import sqe_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
